### hdl/pdi_pkg.sv
// ----------------------------------------------------------------------------
// pdi_pkg
// Shared types and constants of the parking distance indicator: the beat
// structs, configuration layout, action codes and the saturating adder.
// ----------------------------------------------------------------------------
package pdi_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_TABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_BAND       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TIME_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_RECOVERY_MS = 3'd4;

    localparam logic [2:0] ACT_BAR   = 3'd0;
    localparam logic [2:0] ACT_FLASH = 3'd1;
    localparam logic [2:0] ACT_SLEEP = 3'd2;
    localparam logic [2:0] ACT_ERROR = 3'd3;
    localparam logic [2:0] ACT_RESET = 3'd4;
    localparam logic [2:0] ACT_WOKE  = 3'd5;

    localparam logic [7:0] TOO_CLOSE  = 8'd3;
    localparam int unsigned MAX_LEDS  = 8;

    typedef struct packed {
        logic        reading_valid;
        logic [7:0]  distance;
        logic [15:0] elapsed_ms;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] led_flags;
        logic       status_on;
    } t_out_beat;

    typedef struct packed {
        logic [63:0] threshold_table;
        logic [7:0]  stable_band;
        logic [31:0] sleep_delay_ms;
        logic [32:0] flash_end_ms;
        logic [31:0] error_recovery_ms;
    } t_cfg;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

### hdl/pdi_cfg_regs.sv
// ----------------------------------------------------------------------------
// pdi_cfg_regs
// Configuration register file; also keeps the end of the pre-sleep flash
// window (sleep delay plus flash time) as a precomputed 33-bit value.
// ----------------------------------------------------------------------------
module pdi_cfg_regs
    import pdi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD_TABLE:   n_cfg.threshold_table   = i_cfg_data;
                CFG_STABLE_BAND:       n_cfg.stable_band       = i_cfg_data[7:0];
                CFG_SLEEP_DELAY_MS:    n_cfg.sleep_delay_ms    = i_cfg_data[31:0];
                CFG_FLASH_TIME_MS:     n_cfg.flash_end_ms      = r_cfg.flash_end_ms;
                CFG_ERROR_RECOVERY_MS: n_cfg.error_recovery_ms = i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    logic [31:0] r_flash_time_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_table   <= '0;
            r_cfg.stable_band       <= '0;
            r_cfg.sleep_delay_ms    <= '0;
            r_cfg.flash_end_ms      <= '0;
            r_cfg.error_recovery_ms <= '0;
            r_flash_time_ms         <= '0;
        end else begin
            r_cfg.threshold_table   <= n_cfg.threshold_table;
            r_cfg.stable_band       <= n_cfg.stable_band;
            r_cfg.sleep_delay_ms    <= n_cfg.sleep_delay_ms;
            r_cfg.error_recovery_ms <= n_cfg.error_recovery_ms;
            if (i_cfg_we && (i_cfg_idx == CFG_FLASH_TIME_MS)) begin
                r_flash_time_ms <= i_cfg_data[31:0];
            end
            // flash window end is registered from the delay and flash time, following them in the next cycle
            r_cfg.flash_end_ms <= {1'b0, r_cfg.sleep_delay_ms} + {1'b0, r_flash_time_ms};
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/pdi_core.sv
// ----------------------------------------------------------------------------
// pdi_core
// Tracking state and the per-reading decision: stable distance and time,
// gap and error timers, sleep flag; forms the result of one reading.
// ----------------------------------------------------------------------------
module pdi_core
    import pdi_pkg::*;
#(
    parameter int unsigned LED_COUNT = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_take,
    input  t_in_beat  i_beat,
    output t_out_beat o_result
);

    logic [7:0]  r_stable_distance, n_stable_distance;
    logic [31:0] r_stable_time,     n_stable_time;
    logic [31:0] r_gap_time,        n_gap_time;
    logic        r_error_active,    n_error_active;
    logic [31:0] r_error_time,      n_error_time;
    logic        r_asleep,          n_asleep;

    logic [7:0]  diff;
    logic        in_band;
    logic [31:0] el32;
    logic [31:0] delta;
    logic [7:0]  bar;
    t_out_beat   res;

    assign el32    = {16'd0, i_beat.elapsed_ms};
    assign diff    = (i_beat.distance > r_stable_distance) ?
                     (i_beat.distance - r_stable_distance) :
                     (r_stable_distance - i_beat.distance);
    assign in_band = (diff <= i_cfg.stable_band);
    assign delta   = sat_add32(r_gap_time, el32);

    always_comb begin
        bar = '0;
        for (int i = 0; i < MAX_LEDS; i++) begin
            bar[i] = (i < LED_COUNT) && (i_beat.distance < i_cfg.threshold_table[8*i +: 8]);
        end
    end

    always_comb begin
        n_stable_distance = r_stable_distance;
        n_stable_time     = r_stable_time;
        n_gap_time        = r_gap_time;
        n_error_active    = r_error_active;
        n_error_time      = r_error_time;
        n_asleep          = r_asleep;
        res               = '0;
        if (r_asleep) begin
            if (i_beat.reading_valid && in_band) begin
                res.action = ACT_SLEEP;
            end else begin
                n_asleep      = 1'b0;
                res.action    = ACT_WOKE;
                res.status_on = 1'b1;
            end
        end else if (i_beat.reading_valid) begin
            if (in_band) begin
                n_stable_time = sat_add32(r_stable_time, delta);
            end else begin
                n_stable_distance = i_beat.distance;
                n_stable_time     = '0;
            end
            n_gap_time     = '0;
            n_error_active = 1'b0;
            n_error_time   = '0;
            if (n_stable_time >= i_cfg.sleep_delay_ms) begin
                if ({1'b0, n_stable_time} <= i_cfg.flash_end_ms) begin
                    res.action    = ACT_FLASH;
                    res.status_on = 1'b1;
                end else begin
                    n_asleep   = 1'b1;
                    res.action = ACT_SLEEP;
                end
            end else if (i_beat.distance <= TOO_CLOSE) begin
                res.action    = ACT_FLASH;
                res.status_on = 1'b1;
            end else begin
                res.action    = ACT_BAR;
                res.led_flags = bar;
                res.status_on = 1'b1;
            end
        end else begin
            n_gap_time = sat_add32(r_gap_time, el32);
            if (!r_error_active) begin
                n_error_active = 1'b1;
                n_error_time   = '0;
            end else begin
                n_error_time = sat_add32(r_error_time, el32);
            end
            if (n_error_time >= i_cfg.error_recovery_ms) begin
                n_stable_distance = '0;
                n_stable_time     = '0;
                n_gap_time        = '0;
                n_error_active    = 1'b0;
                n_error_time      = '0;
                n_asleep          = 1'b0;
                res.action        = ACT_RESET;
            end else begin
                res.action = ACT_ERROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_distance <= '0;
            r_stable_time     <= '0;
            r_gap_time        <= '0;
            r_error_active    <= 1'b0;
            r_error_time      <= '0;
            r_asleep          <= 1'b0;
        end else if (i_take) begin
            r_stable_distance <= n_stable_distance;
            r_stable_time     <= n_stable_time;
            r_gap_time        <= n_gap_time;
            r_error_active    <= n_error_active;
            r_error_time      <= n_error_time;
            r_asleep          <= n_asleep;
        end
    end

    assign o_result = res;

endmodule

### hdl/parking_distance_indicator_unit.sv
// ----------------------------------------------------------------------------
// parking_distance_indicator_unit
// Parking distance indicator: range readings in, LED/status actions out.
// ----------------------------------------------------------------------------
// Each input beat is one range reading and gives exactly one result beat.
// A reading is captured in an input register and decided from it, the result
// landing in an output register; one reading can be taken every cycle while
// the output does not stall, the rate being set by the single decision stage,
// which updates the tracking state as the result is written.
// The input stalls only while a finished result is held by a stalled output
// and a second reading already waits in the input register. Configuration
// writes take effect for readings accepted after the write.
module parking_distance_indicator_unit
    import pdi_pkg::*;
#(
    parameter int unsigned LED_COUNT = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    t_cfg      cfg;
    t_out_beat result;
    logic      advance;
    logic      take;

    logic      r_s1_valid;
    t_in_beat  r_s1_beat;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    pdi_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pdi_core #(
        .LED_COUNT (LED_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_take   (take),
        .i_beat   (r_s1_beat),
        .o_result (result)
    );

    assign advance    = !r_out_valid || !i_out_stall;
    assign take       = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_beat <= result;
        end
        if (!o_in_stall && i_in_valid) begin
            r_s1_beat <= i_in_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

endmodule

### hdl/pdi_checker.sv
// ----------------------------------------------------------------------------
// pdi_checker
// Port-level checks of the parking distance indicator, bound to the top.
// ----------------------------------------------------------------------------
module pdi_checker
    import pdi_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // bar pattern only with the bar action
    a_leds_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.led_flags != 8'd0) |-> o_out_data.action == ACT_BAR)
        else $error("led flags set outside bar action");

    // status steady on for bar, flash and woke
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status_on ==
            ((o_out_data.action == ACT_BAR) || (o_out_data.action == ACT_FLASH) ||
             (o_out_data.action == ACT_WOKE)))
        else $error("status light does not match action");

    // a fresh result follows an input beat accepted into the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && $past(i_rst_n, 2) |->
            $past(i_in_valid && !o_in_stall, 2))
        else $error("result beat without an input beat");

    // nothing shown right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind parking_distance_indicator_unit pdi_checker u_pdi_checker (.*);

### tb/sv/tb_parking_distance_indicator_unit.sv
// ----------------------------------------------------------------------------
// tb_parking_distance_indicator_unit
// Self-checking bench for the parking distance indicator. A short directed
// table covers reset behavior, bar extremes, too-close flash, error recovery,
// sleep and wake. It is followed by randomized parking approaches with error
// bursts under several register settings. Each result beat is held against
// a table beat or a cycle-free tracking model; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_parking_distance_indicator_unit;
    import pdi_pkg::*;

    localparam int unsigned LEDS            = 8;
    localparam int          PHASES          = 8;
    localparam int          READINGS_PHASE  = 125;
    localparam int          DIRECTED_COUNT  = 26;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_in_beat              reading;
        bit                    typed;
        t_out_beat             want;
    } t_dir_row;

    // the first rows run with all registers at zero
    localparam t_dir_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{1'b0, '0, '0, '{1'b1, 8'd0, 16'd0}, 1'b1, '{ACT_FLASH, 8'h00, 1'b1}},
        '{1'b0, '0, '0, '{1'b1, 8'd255, 16'd65535}, 1'b1, '{ACT_FLASH, 8'h00, 1'b1}},
        '{1'b0, '0, '0, '{1'b1, 8'd255, 16'd1}, 1'b1, '{ACT_SLEEP, 8'h00, 1'b0}},
        '{1'b0, '0, '0, '{1'b0, 8'd0, 16'd0}, 1'b1, '{ACT_WOKE, 8'h00, 1'b1}},
        '{1'b0, '0, '0, '{1'b0, 8'd0, 16'd65535}, 1'b1, '{ACT_RESET, 8'h00, 1'b0}},
        '{1'b1, CFG_THRESHOLD_TABLE, 64'hFFE0_C0A0_8060_4020, '0, 1'b0, '0},
        '{1'b1, CFG_STABLE_BAND, 64'd3, '0, 1'b0, '0},
        '{1'b1, CFG_SLEEP_DELAY_MS, 64'd1000, '0, 1'b0, '0},
        '{1'b1, CFG_FLASH_TIME_MS, 64'd400, '0, 1'b0, '0},
        '{1'b1, CFG_ERROR_RECOVERY_MS, 64'd500, '0, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd255, 16'd0}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd4, 16'd100}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd3, 16'd100}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd0, 16'd100}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd100, 16'd300}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b0, 8'd170, 16'd200}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b0, 8'd85, 16'd499}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd101, 16'd500}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd99, 16'd300}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd102, 16'd65535}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd200, 16'd5}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b1, 8'd100, 16'd0}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b0, 8'd0, 16'd0}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b0, 8'd0, 16'd1}, 1'b0, '0},
        '{1'b0, '0, '0, '{1'b0, 8'd255, 16'd65535}, 1'b1, '{ACT_RESET, 8'h00, 1'b0}},
        '{1'b0, '0, '0, '{1'b1, 8'd3, 16'd0}, 1'b0, '0}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out_data;

    parking_distance_indicator_unit #(
        .LED_COUNT(LEDS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // register shadows
    logic [63:0] cfg_thresholds;
    logic [7:0]  cfg_band;
    logic [31:0] cfg_sleep_delay;
    logic [31:0] cfg_flash_time;
    logic [31:0] cfg_err_recovery;

    // tracking state
    logic [7:0]  trk_dist;
    logic [31:0] trk_stable_ms;
    logic [31:0] trk_gap_ms;
    logic [31:0] trk_err_ms;
    bit          trk_err_active;
    bit          trk_asleep;

    t_out_beat   pending_indications[$];
    int          mismatches;
    int          results_seen;
    int          sender_gap_pct;
    int          receiver_stall_pct;
    int          approach_dist;
    int          err_burst_left;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] add_clip(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void clear_tracking();
        trk_dist       = '0;
        trk_stable_ms  = '0;
        trk_gap_ms     = '0;
        trk_err_ms     = '0;
        trk_err_active = 1'b0;
        trk_asleep     = 1'b0;
    endfunction

    function automatic bit in_band(input logic [7:0] d);
        logic [7:0] diff;
        diff = (d > trk_dist) ? d - trk_dist : trk_dist - d;
        return diff <= cfg_band;
    endfunction

    function automatic logic [7:0] led_bar(input logic [7:0] d);
        logic [7:0] flags;
        flags = '0;
        for (int i = 0; i < LEDS; i++) begin
            flags[i] = d < cfg_thresholds[8*i +: 8];
        end
        return flags;
    endfunction

    function automatic t_out_beat predict_indication(input t_in_beat b);
        t_out_beat   r;
        logic [31:0] delta;
        logic [32:0] flash_end;
        r = '0;
        if (trk_asleep) begin
            if (b.reading_valid && in_band(b.distance)) begin
                r.action = ACT_SLEEP;
            end else begin
                trk_asleep  = 1'b0;
                r.action    = ACT_WOKE;
                r.status_on = 1'b1;
            end
        end else if (b.reading_valid) begin
            delta = add_clip(trk_gap_ms, {16'h0, b.elapsed_ms});
            if (in_band(b.distance)) begin
                trk_stable_ms = add_clip(trk_stable_ms, delta);
            end else begin
                trk_dist      = b.distance;
                trk_stable_ms = '0;
            end
            trk_gap_ms     = '0;
            trk_err_active = 1'b0;
            trk_err_ms     = '0;
            flash_end      = {1'b0, cfg_sleep_delay} + {1'b0, cfg_flash_time};
            if (trk_stable_ms >= cfg_sleep_delay) begin
                if ({1'b0, trk_stable_ms} <= flash_end) begin
                    r.action    = ACT_FLASH;
                    r.status_on = 1'b1;
                end else begin
                    trk_asleep = 1'b1;
                    r.action   = ACT_SLEEP;
                end
            end else if (b.distance <= TOO_CLOSE) begin
                r.action    = ACT_FLASH;
                r.status_on = 1'b1;
            end else begin
                r.action    = ACT_BAR;
                r.led_flags = led_bar(b.distance);
                r.status_on = 1'b1;
            end
        end else begin
            trk_gap_ms = add_clip(trk_gap_ms, {16'h0, b.elapsed_ms});
            if (!trk_err_active) begin
                trk_err_active = 1'b1;
                trk_err_ms     = '0;
            end else begin
                trk_err_ms = add_clip(trk_err_ms, {16'h0, b.elapsed_ms});
            end
            if (trk_err_ms >= cfg_err_recovery) begin
                clear_tracking();
                r.action = ACT_RESET;
            end else begin
                r.action = ACT_ERROR;
            end
        end
        return r;
    endfunction

    // slow approach toward the wall with jitter, jumps and sensor dropouts
    function automatic t_in_beat random_reading();
        t_in_beat b;
        int       roll;
        int       d;
        int       offset;
        roll = $urandom_range(99);
        b.reading_valid = 1'b1;
        b.elapsed_ms    = ($urandom_range(29) == 0) ? 16'($urandom_range(65535))
                                                    : 16'($urandom_range(250));
        if (err_burst_left > 0 || roll < 5) begin
            if (err_burst_left == 0) begin
                err_burst_left = $urandom_range(14) + 1;
            end
            err_burst_left--;
            b.reading_valid = 1'b0;
            b.distance      = 8'($urandom_range(255));
            return b;
        end
        if (roll < 11) begin
            approach_dist = ($urandom_range(3) == 0) ? $urandom_range(6)
                                                     : $urandom_range(255);
        end else if (roll < 22 && approach_dist > 0) begin
            approach_dist = approach_dist - $urandom_range(1);
        end
        if (roll >= 94) begin
            b.distance = 8'($urandom_range(255));
        end else begin
            offset = $urandom_range(int'(cfg_band));
            if ($urandom_range(6) == 0) begin
                offset = offset + 1 + $urandom_range(3);
            end
            d = $urandom_range(1) ? approach_dist + offset : approach_dist - offset;
            if (d < 0) d = 0;
            if (d > 255) d = 255;
            b.distance = 8'(d);
        end
        return b;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_indications.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD_TABLE:   cfg_thresholds   = value;
            CFG_STABLE_BAND:       cfg_band         = value[7:0];
            CFG_SLEEP_DELAY_MS:    cfg_sleep_delay  = value[31:0];
            CFG_FLASH_TIME_MS:     cfg_flash_time   = value[31:0];
            CFG_ERROR_RECOVERY_MS: cfg_err_recovery = value[31:0];
            default: ;
        endcase
    endtask

    task automatic send_reading(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat predicted;
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_indication(b);
        pending_indications.push_back(typed ? want : predicted);
    endtask

    task automatic program_setting(input int kind);
        logic [CFG_DATA_W-1:0] table_val;
        logic [CFG_DATA_W-1:0] band_val;
        logic [CFG_DATA_W-1:0] sleep_val;
        logic [CFG_DATA_W-1:0] flash_val;
        logic [CFG_DATA_W-1:0] recover_val;
        case (kind)
            1: begin
                table_val   = '0;
                band_val    = '0;
                sleep_val   = '0;
                flash_val   = '0;
                recover_val = '0;
            end
            2: begin
                table_val   = '1;
                band_val    = 64'hFF;
                sleep_val   = 64'hFFFF_FFFF;
                flash_val   = 64'hFFFF_FFFF;
                recover_val = 64'hFFFF_FFFF;
            end
            default: begin
                table_val   = {32'($urandom), 32'($urandom)};
                band_val    = 64'($urandom_range(8));
                sleep_val   = 64'($urandom_range(3000));
                flash_val   = 64'($urandom_range(2000));
                recover_val = 64'($urandom_range(1200));
            end
        endcase
        write_reg(CFG_THRESHOLD_TABLE, table_val);
        write_reg(CFG_STABLE_BAND, band_val);
        write_reg(CFG_SLEEP_DELAY_MS, sleep_val);
        write_reg(CFG_FLASH_TIME_MS, flash_val);
        write_reg(CFG_ERROR_RECOVERY_MS, recover_val);
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_indications.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result beat %0d unexpected: action %0d leds %h status %0b",
                             results_seen, o_out_data.action, o_out_data.led_flags,
                             o_out_data.status_on);
                end
            end else begin
                want = pending_indications.pop_front();
                if (o_out_data.action !== want.action
                        || o_out_data.led_flags !== want.led_flags
                        || o_out_data.status_on !== want.status_on) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"result beat %0d: expected action %0d leds %h ",
                                  "status %0b, got action %0d leds %h status %0b"},
                                 results_seen, want.action, want.led_flags, want.status_on,
                                 o_out_data.action, o_out_data.led_flags,
                                 o_out_data.status_on);
                    end
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    initial begin
        cfg_thresholds     = '0;
        cfg_band           = '0;
        cfg_sleep_delay    = '0;
        cfg_flash_time     = '0;
        cfg_err_recovery   = '0;
        clear_tracking();
        mismatches         = 0;
        results_seen       = 0;
        approach_dist      = 120;
        err_burst_left     = 0;
        sender_gap_pct     = 11;
        receiver_stall_pct = 45;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_COUNT; k++) begin
            if (DIRECTED_ROWS[k].is_cfg) begin
                write_reg(DIRECTED_ROWS[k].reg_idx, DIRECTED_ROWS[k].reg_data);
            end else begin
                send_reading(DIRECTED_ROWS[k].reading, DIRECTED_ROWS[k].typed,
                             DIRECTED_ROWS[k].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            if (phase < 3) begin
                sender_gap_pct     = 11;
                receiver_stall_pct = 45;
            end else if (phase < 6) begin
                sender_gap_pct     = 45;
                receiver_stall_pct = 11;
            end else begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            // one all-zero and one all-ones setting among the random ones
            program_setting(phase == 1 ? 1 : (phase == 4 ? 2 : 0));
            repeat (READINGS_PHASE) send_reading(random_reading(), 1'b0, '0);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_indications.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
